[rtl/svwap_pkg.sv]
package svwap_pkg;

	localparam int WINDOW_DEPTH = 100;

	localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

	localparam int PRICE_W = 32;
	localparam int VOL_W   = 32;
	localparam int MUL_W   = 63;
	localparam int FRAC_W  = 8;
	localparam int PROD_W  = 56;
	localparam int PSUM_W  = PROD_W + CNT_W;
	localparam int VSUM_W  = VOL_W + CNT_W;

	localparam int AVG_W   = 31;
	localparam int TIW_W   = 7;
	localparam int DIV_SHIFT = AVG_W - FRAC_W;
	localparam int HI_W    = PSUM_W - DIV_SHIFT;
	localparam int STEP_W  = $clog2(AVG_W);

	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

	typedef struct packed {
		logic [VOL_W-1:0]  vol;
		logic [PROD_W-1:0] prod;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

endpackage

[rtl/svwap_ram.sv]
module svwap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/sliding_window_vwap.sv]
// Sliding-window volume-weighted average price. Each input beat is one trade:
// a signed Q8 price and an unsigned Q8 volume. A trade with price zero or
// negative is dropped and gives no output beat. Any other trade replaces the
// oldest of the last 100 trades once the window is full, and one output beat
// gives the average price (Q8, truncated, saturated to 31 bits), the number
// of trades held and a flag for a zero window volume, in which case the price
// is 0. Running sums are updated from the new and evicted entries. A trade
// passes a state each for the product, the eviction, the insertion and the
// range check, then 31 steps of a radix-2 restoring divider, one quotient
// bit a cycle; the divider is skipped when the window volume is zero or the
// average saturates. The input is not ready while a trade is in work; a
// finished result waits in the output register while the next trade is
// taken.
module sliding_window_vwap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // price[31:0], volume[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // average_price[30:0], trades_in_window[37:31], zero pad
	output logic        m_tuser   // zero_volume
);

	logic [2:0] state_q;

	logic [svwap_pkg::PRICE_W-2:0] price_q;
	logic [svwap_pkg::VOL_W-1:0]   vol_q;
	logic [svwap_pkg::MUL_W-1:0]   mul_q;
	logic [svwap_pkg::PROD_W-1:0]  prod_q;
	logic [svwap_pkg::PSUM_W-1:0]  psum_q;
	logic [svwap_pkg::VSUM_W-1:0]  vsum_q;
	logic [svwap_pkg::ADDR_W-1:0]  pos_q;
	logic [svwap_pkg::CNT_W-1:0]   fill_q;
	logic [svwap_pkg::VSUM_W-1:0]  rem_q;
	logic [svwap_pkg::AVG_W-1:0]   quo_q;
	logic [svwap_pkg::STEP_W-1:0]  step_q;
	logic                          zv_q;

	logic [svwap_pkg::AVG_W-1:0]   avg_out_q;
	logic [svwap_pkg::TIW_W-1:0]   tiw_out_q;
	logic                          zv_out_q;
	logic                          m_valid_q;

	svwap_pkg::entry_t wr_entry;
	svwap_pkg::entry_t rd_entry;
	logic [svwap_pkg::ENTRY_W-1:0] rd_raw;

	logic        full;
	logic        accept;
	logic        skip;
	logic [63:0] mul_rnd;
	logic [svwap_pkg::VSUM_W:0]   rem_sh;
	logic [svwap_pkg::VSUM_W+1:0] rem_diff;
	logic                         rem_ge;
	logic                         out_free;

	assign full     = (fill_q == svwap_pkg::CNT_W'(svwap_pkg::WINDOW_DEPTH));
	assign s_tready = (state_q == svwap_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign skip     = (s_tdata[31:0] == 32'd0) || s_tdata[31];
	assign out_free = !m_valid_q || m_tready;

	assign mul_rnd  = {1'b0, mul_q} + 64'd128;

	// one quotient bit per step
	assign rem_sh   = {rem_q, quo_q[svwap_pkg::AVG_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, vsum_q};
	assign rem_ge   = !rem_diff[svwap_pkg::VSUM_W+1];

	assign wr_entry.vol  = vol_q;
	assign wr_entry.prod = prod_q;
	assign rd_entry      = rd_raw;

	svwap_ram #(
		.WIDTH(svwap_pkg::ENTRY_W),
		.DEPTH(svwap_pkg::WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == svwap_pkg::ST_ADD),
		.waddr (pos_q),
		.wdata (wr_entry),
		.raddr (pos_q),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svwap_pkg::ST_IDLE;
			psum_q  <= '0;
			vsum_q  <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				svwap_pkg::ST_IDLE: begin
					if (accept && !skip) begin
						state_q <= svwap_pkg::ST_MUL;
					end
				end
				svwap_pkg::ST_MUL: begin
					state_q <= svwap_pkg::ST_SUB;
				end
				svwap_pkg::ST_SUB: begin
					if (full) begin
						psum_q <= psum_q - svwap_pkg::PSUM_W'(rd_entry.prod);
						vsum_q <= vsum_q - svwap_pkg::VSUM_W'(rd_entry.vol);
					end
					state_q <= svwap_pkg::ST_ADD;
				end
				svwap_pkg::ST_ADD: begin
					psum_q <= psum_q + svwap_pkg::PSUM_W'(prod_q);
					vsum_q <= vsum_q + svwap_pkg::VSUM_W'(vol_q);
					if (pos_q == svwap_pkg::ADDR_W'(svwap_pkg::WINDOW_DEPTH - 1)) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= svwap_pkg::ST_CHK;
				end
				svwap_pkg::ST_CHK: begin
					step_q <= '0;
					if (vsum_q == '0) begin
						state_q <= svwap_pkg::ST_OUT;
					end else if (psum_q[svwap_pkg::PSUM_W-1:svwap_pkg::DIV_SHIFT]
							>= svwap_pkg::HI_W'(vsum_q)) begin
						state_q <= svwap_pkg::ST_OUT;
					end else begin
						state_q <= svwap_pkg::ST_DIV;
					end
				end
				svwap_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == svwap_pkg::STEP_W'(svwap_pkg::AVG_W - 1)) begin
						state_q <= svwap_pkg::ST_OUT;
					end
				end
				svwap_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= svwap_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= svwap_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q <= s_tdata[30:0];
			vol_q   <= s_tdata[63:32];
		end
		if (state_q == svwap_pkg::ST_MUL) begin
			mul_q <= {32'd0, price_q} * {31'd0, vol_q};
		end
		if (state_q == svwap_pkg::ST_SUB) begin
			prod_q <= mul_rnd[63:8];
		end
		if (state_q == svwap_pkg::ST_CHK) begin
			rem_q <= psum_q[svwap_pkg::DIV_SHIFT +: svwap_pkg::VSUM_W];
			zv_q  <= (vsum_q == '0);
			if (vsum_q == '0) begin
				quo_q <= '0;
			end else if (psum_q[svwap_pkg::PSUM_W-1:svwap_pkg::DIV_SHIFT]
					>= svwap_pkg::HI_W'(vsum_q)) begin
				quo_q <= svwap_pkg::AVG_MAX;
			end else begin
				quo_q <= {psum_q[svwap_pkg::DIV_SHIFT-1:0], svwap_pkg::FRAC_W'(0)};
			end
		end
		if (state_q == svwap_pkg::ST_DIV) begin
			rem_q <= rem_ge ? rem_diff[svwap_pkg::VSUM_W-1:0]
			                : rem_sh[svwap_pkg::VSUM_W-1:0];
			quo_q <= {quo_q[svwap_pkg::AVG_W-2:0], rem_ge};
		end
		if (state_q == svwap_pkg::ST_OUT && out_free) begin
			avg_out_q <= quo_q;
			tiw_out_q <= svwap_pkg::TIW_W'(fill_q);
			zv_out_q  <= zv_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == svwap_pkg::ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, tiw_out_q, avg_out_q};
	assign m_tuser  = zv_out_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= svwap_pkg::CNT_W'(svwap_pkg::WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (svwap_pkg::CNT_W'(pos_q) == fill_q))
		else $error("write position out of step with fill count");

	a_zero_vol_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vsum_q == '0 |-> psum_q == '0)
		else $error("product sum nonzero with zero volume sum");

	a_zero_vol_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[svwap_pkg::AVG_W-1:0] == '0))
		else $error("zero volume beat with nonzero price");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svwap_pkg::ST_DIV) |=> !s_tready || $past(step_q)
			== svwap_pkg::STEP_W'(svwap_pkg::AVG_W - 1) || state_q == svwap_pkg::ST_OUT)
		else $error("input ready during division");
`endif

endmodule

[sim/sliding_window_vwap_tb.sv]
`timescale 1ns / 1ps

module sliding_window_vwap_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_TRADES = 350;
	localparam int DRAIN_WAIT    = 60;

	typedef struct {
		logic [31:0] price;
		logic [31:0] volume;
		bit          drain;
	} trade_t;

	typedef struct {
		logic [svwap_pkg::AVG_W-1:0] average;
		logic [svwap_pkg::TIW_W-1:0] held;
		logic                        zero_vol;
	} vwap_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	trade_t trade_q[$];
	vwap_t  vwap_due[$];

	// window copy for prediction
	logic [svwap_pkg::PROD_W-1:0] product_ring[svwap_pkg::WINDOW_DEPTH];
	logic [svwap_pkg::VOL_W-1:0]  volume_ring[svwap_pkg::WINDOW_DEPTH];
	int                ring_slot = 0;
	int                ring_held = 0;
	logic [63:0]       product_total = '0;
	logic [39:0]       volume_total = '0;

	int  results_due = 0;
	int  results_seen = 0;
	int  errors = 0;
	int  trades_sent = 0;
	int  trades_skipped = 0;
	int  zero_vol_seen = 0;
	int  saturated_seen = 0;
	int  cycle_count = 0;
	bit  calm;

	sliding_window_vwap DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign calm = (cycle_count >= 4000) && (cycle_count < 8000);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				vwap_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic predict_vwap(input trade_t t, output bit produced);
		logic [63:0]                  full;
		logic [svwap_pkg::PROD_W-1:0] prod;
		logic [71:0]                  quotient;
		vwap_t                        r;
		produced = 1'b0;
		if (t.price == 32'd0 || t.price[31]) begin
			trades_skipped++;
			return;
		end
		full = 64'(t.price) * 64'(t.volume) + 64'd128;
		prod = full[63:8];
		if (ring_held >= svwap_pkg::WINDOW_DEPTH) begin
			product_total -= 64'(product_ring[ring_slot]);
			volume_total  -= 40'(volume_ring[ring_slot]);
		end else begin
			ring_held++;
		end
		product_ring[ring_slot] = prod;
		volume_ring[ring_slot]  = t.volume;
		product_total += 64'(prod);
		volume_total  += 40'(t.volume);
		ring_slot = (ring_slot + 1 >= svwap_pkg::WINDOW_DEPTH) ? 0 : ring_slot + 1;
		if (volume_total == '0) begin
			r.average  = '0;
			r.zero_vol = 1'b1;
		end else begin
			quotient   = {product_total, 8'd0} / 72'(volume_total);
			r.average  = (quotient > 72'(svwap_pkg::AVG_MAX)) ? svwap_pkg::AVG_MAX
				: quotient[svwap_pkg::AVG_W-1:0];
			r.zero_vol = 1'b0;
		end
		r.held = svwap_pkg::TIW_W'(ring_held);
		vwap_due.insert(vwap_due.size(), r);
		produced = 1'b1;
	endtask

	// trade driver
	always @(posedge clk or negedge arst_n) begin
		bit produced;
		int outstanding;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			produced = 1'b0;
			if (s_tvalid && s_tready) begin
				predict_vwap(trade_q.pop_front(), produced);
				trades_sent++;
				if (produced)
					results_due <= results_due + 1;
			end
			outstanding = results_due - results_seen + int'(produced);
			if (!s_tvalid || s_tready) begin
				if (trade_q.size() > 0 && (calm || $urandom_range(99) >= 32) &&
					!(trade_q[0].drain && outstanding != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {trade_q[0].volume, trade_q[0].price};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		vwap_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (vwap_due.size() == 0) begin
					$display("%0t: unexpected beat, actual avg %h held %0d zero %b", $time,
						m_tdata[30:0], m_tdata[37:31], m_tuser);
					errors++;
				end else begin
					want = vwap_due.pop_front();
					if (m_tdata[30:0] !== want.average) begin
						$display("%0t: average_price expected %h actual %h", $time,
							want.average, m_tdata[30:0]);
						errors++;
					end
					if (m_tdata[37:31] !== want.held) begin
						$display("%0t: trades_in_window expected %0d actual %0d", $time,
							want.held, m_tdata[37:31]);
						errors++;
					end
					if (m_tuser !== want.zero_vol) begin
						$display("%0t: zero_volume expected %b actual %b", $time,
							want.zero_vol, m_tuser);
						errors++;
					end
					if (want.zero_vol)
						zero_vol_seen++;
					if (want.average == svwap_pkg::AVG_MAX)
						saturated_seen++;
				end
			end
			m_tready <= calm || ($urandom_range(99) >= 32);
		end
	end

	function automatic logic [31:0] pick_price();
		logic [31:0] p;
		case ($urandom_range(9))
			0: p = $urandom_range(1) ? {1'b1, 31'($urandom)} : 32'd0;
			1: p = 32'h7FFF_FFFF;
			2: p = $urandom_range(255, 1);
			3: p = $urandom_range(32'hFFFF, 1);
			default: begin
				p = {1'b0, 31'($urandom)};
				if (p == 32'd0)
					p = 32'd1;
			end
		endcase
		return p;
	endfunction

	function automatic logic [31:0] pick_volume();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'd0;
			1: v = $urandom_range(3, 1);
			2: v = 32'hFFFF_FFFF;
			3: v = $urandom_range(32'hFFFF, 1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic add_trade(input logic [31:0] p, input logic [31:0] v, input bit drain);
		trade_t t;
		t.price  = p;
		t.volume = v;
		t.drain  = drain;
		trade_q.insert(trade_q.size(), t);
	endtask

	initial begin
		int valid_made;
		trade_t t;
		// directed: empty window with zero volume, skips, saturation, rounding, extremes
		add_trade(32'h0000_0100, 32'd0, 1'b0);
		add_trade(32'h0000_0000, 32'd5, 1'b0);
		add_trade(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		add_trade(32'hFFFF_FFFF, 32'd1, 1'b0);
		add_trade(32'h7FFF_FFFF, 32'd1, 1'b0);
		add_trade(32'h7FFF_FFFF, 32'd0, 1'b1);
		add_trade(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		add_trade(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_trade(32'h0000_0001, 32'd1, 1'b0);
		add_trade(32'h0000_0080, 32'd1, 1'b0);
		add_trade(32'h0000_007F, 32'd1, 1'b0);
		add_trade(32'h0000_0100, 32'h0000_0100, 1'b0);
		add_trade(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		add_trade(32'h2AAA_AAAA, 32'h5555_5555, 1'b0);
		add_trade(32'h1234_5678, 32'h0000_0100, 1'b1);
		add_trade(32'hDEAD_BEEF, 32'h0000_0000, 1'b0);
		add_trade(32'h0000_0001, 32'd0, 1'b0);
		// random: a long zero-volume run pushes the window volume back to zero
		valid_made = 0;
		while (valid_made < RANDOM_TRADES) begin
			t.price  = pick_price();
			t.volume = (valid_made >= 150 && valid_made < 265) ? 32'd0 : pick_volume();
			t.drain  = (valid_made == 150) || ($urandom_range(99) == 0);
			trade_q.insert(trade_q.size(), t);
			if (t.price != 32'd0 && !t.price[31])
				valid_made++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (trade_q.size() == 0);
		@(posedge clk);
		wait (results_due == results_seen);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (vwap_due.size() != 0) begin
			$display("%0t: %0d results never arrived, first expected avg %h held %0d",
				$time, vwap_due.size(), vwap_due[0].average, vwap_due[0].held);
			errors++;
		end
		$display("%0d trades sent (%0d skipped), %0d averages checked", trades_sent,
			trades_skipped, results_seen);
		$display("%0d zero-volume windows, %0d saturated averages, %0d mismatches",
			zero_vol_seen, saturated_seen, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
